FILE: src/gsa_pkg.sv
// gsa_pkg: types, codes and field widths shared by the slot allocator files.
// No dependencies.
`default_nettype none
package gsa_pkg;

   localparam int IDX_W   = 4;
   localparam int GEN_W   = 32;
   localparam int EPOCH_W = 64;
   localparam int SIZE_W  = 5;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 3;

   // slots per pool; bound to the 4-bit index and 5-bit size register widths
   localparam int SLOTS_PER_POOL = 16;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC      = 2'd0,
      ACT_RELEASE    = 2'd1,
      ACT_SET_RETIRE = 2'd2,
      ACT_COLLECT    = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EXHAUSTED = 3'd1,
      ST_RANGE     = 3'd2,
      ST_DEFAULT   = 3'd3,
      ST_STALE     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_ALLOC_POP,
      FSM_ALLOC_GEN,
      FSM_ALLOC_OUT,
      FSM_REL_READ,
      FSM_REL_DONE,
      FSM_SET_RET,
      FSM_COL_START,
      FSM_COL_READ,
      FSM_COL_EVAL,
      FSM_COL_END
   } fsm_type;

   typedef enum logic [2:0] {
      EMIT_ALLOC_EMPTY,
      EMIT_ALLOC,
      EMIT_RELEASE,
      EMIT_ZERO,
      EMIT_COL_END
   } emit_type;

   // CSR register indexes
   localparam logic CSR_SAMPLED_SIZE = 1'b0;
   localparam logic CSR_STORAGE_SIZE = 1'b1;

   typedef struct packed {
      logic     latch;
      logic     alloc_pop;
      logic     alloc_gen_rd;
      logic     rel_gen_rd;
      logic     rel_finish;
      logic     set_ret;
      logic     col_init;
      logic     col_rd;
      logic     col_eval;
      logic     emit;
      emit_type kind;
   } cmd_type;

   typedef struct packed {
      logic alloc_empty;
      logic pend_empty;
      logic col_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

FILE: src/gsa_ctrl.sv
// gsa_ctrl: sequencer for the slot allocator.
// Depends on gsa_pkg; drives the command struct of gsa_dp.
`default_nettype none
module gsa_ctrl import gsa_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [ACT_W-1:0] req_action,
   output logic                  req_ready,
   input  wire stat_type         stat,
   output cmd_type               cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_ALLOC:      state_in = FSM_ALLOC_POP;
                  ACT_RELEASE:    state_in = FSM_REL_READ;
                  ACT_SET_RETIRE: state_in = FSM_SET_RET;
                  ACT_COLLECT:    state_in = FSM_COL_START;
                  default:        state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_ALLOC_POP: begin
            if (stat.alloc_empty) begin
               if (stat.out_free) state_in = FSM_IDLE;
            end else begin
               state_in = FSM_ALLOC_GEN;
            end
         end
         FSM_ALLOC_GEN: state_in = FSM_ALLOC_OUT;
         FSM_ALLOC_OUT: if (stat.out_free) state_in = FSM_IDLE;
         FSM_REL_READ:  state_in = FSM_REL_DONE;
         FSM_REL_DONE:  if (stat.out_free) state_in = FSM_IDLE;
         FSM_SET_RET:   if (stat.out_free) state_in = FSM_IDLE;
         FSM_COL_START: state_in = stat.pend_empty ? FSM_COL_END : FSM_COL_READ;
         FSM_COL_READ:  state_in = FSM_COL_EVAL;
         FSM_COL_EVAL: begin
            if (stat.out_free) state_in = stat.col_last ? FSM_COL_END : FSM_COL_READ;
         end
         FSM_COL_END:   if (stat.out_free) state_in = FSM_IDLE;
         default:       state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = EMIT_ZERO;
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         FSM_ALLOC_POP: begin
            if (stat.alloc_empty) begin
               cmd.emit = stat.out_free;
               cmd.kind = EMIT_ALLOC_EMPTY;
            end else begin
               cmd.alloc_pop = 1'b1;
            end
         end
         FSM_ALLOC_GEN: cmd.alloc_gen_rd = 1'b1;
         FSM_ALLOC_OUT: begin
            cmd.emit = stat.out_free;
            cmd.kind = EMIT_ALLOC;
         end
         FSM_REL_READ: cmd.rel_gen_rd = 1'b1;
         FSM_REL_DONE: begin
            cmd.rel_finish = stat.out_free;
            cmd.emit       = stat.out_free;
            cmd.kind       = EMIT_RELEASE;
         end
         FSM_SET_RET: begin
            cmd.set_ret = stat.out_free;
            cmd.emit    = stat.out_free;
            cmd.kind    = EMIT_ZERO;
         end
         FSM_COL_START: cmd.col_init = 1'b1;
         FSM_COL_READ:  cmd.col_rd   = 1'b1;
         FSM_COL_EVAL:  cmd.col_eval = stat.out_free;
         FSM_COL_END: begin
            cmd.emit = stat.out_free;
            cmd.kind = EMIT_COL_END;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/gsa_dp.sv
// gsa_dp: free stacks, generation table, pending queue and result register.
// Depends on gsa_pkg; sequenced by gsa_ctrl.
`default_nettype none
module gsa_dp import gsa_pkg::*; #(
   parameter int PENDING_DEPTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic               req_pool,
   input  wire logic [IDX_W-1:0]   req_slot_index,
   input  wire logic [GEN_W-1:0]   req_handle_generation,
   input  wire logic [EPOCH_W-1:0] req_epoch_value,
   input  wire logic               cfg_we,
   input  wire logic               cfg_sel,
   input  wire logic [SIZE_W-1:0]  cfg_data,
   output logic [SIZE_W-1:0]       size_rd [2],
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [STAT_W-1:0]       rsp_status,
   output logic                    rsp_result_pool,
   output logic [IDX_W-1:0]        rsp_result_index,
   output logic [GEN_W-1:0]        rsp_result_generation,
   output logic                    rsp_freed_valid,
   output logic                    rsp_last
);

   localparam int SLOT_W  = $clog2(SLOTS_PER_POOL);
   localparam int CNT_W   = $clog2(SLOTS_PER_POOL + 1);
   localparam int PEND_W  = $clog2(PENDING_DEPTH);
   localparam int PCNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int ENT_W   = SLOT_W + 1;
   localparam int TAB_D   = 2 * (1 << SLOT_W);

   // latched transaction
   logic               pool_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [GEN_W-1:0]   hgen_ff;
   logic [EPOCH_W-1:0] epoch_ff;

   logic [CNT_W-1:0] size_ff [2];
   logic [CNT_W-1:0] size_in [2];
   logic [CNT_W-1:0] cnt_ff  [2];
   logic [CNT_W-1:0] cnt_in  [2];
   logic [CNT_W-1:0] low_ff  [2];
   logic [CNT_W-1:0] low_in  [2];

   logic [SLOT_W-1:0] stk_mem [TAB_D];
   logic [SLOT_W-1:0] stk_q_ff;
   logic              below_ff;
   logic [SLOT_W-1:0] synth_ff;

   logic [GEN_W-1:0] gen_mem [TAB_D];
   logic [GEN_W-1:0] gen_q_ff;
   logic             gvq_ff;
   logic [TAB_D-1:0] gvld_ff, gvld_in;

   logic [EPOCH_W-1:0] pv_mem [PENDING_DEPTH];
   logic [ENT_W-1:0]   ps_mem [PENDING_DEPTH];
   logic [EPOCH_W-1:0] pv_q_ff;
   logic [ENT_W-1:0]   ps_q_ff;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [PCNT_W-1:0]  k_ff, k_in;
   logic [PCNT_W-1:0]  keep_ff, keep_in;

   logic [EPOCH_W-1:0] cur_ret_ff;

   logic              hold_vld_ff, hold_vld_in;
   logic              hold_pool_ff;
   logic [SLOT_W-1:0] hold_slot_ff;

   logic              out_vld_ff;
   status_type        out_st_ff, out_st_in;
   logic              out_pool_ff, out_pool_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [GEN_W-1:0]  out_gen_ff, out_gen_in;
   logic              out_freed_ff, out_freed_in;
   logic              out_last_ff, out_last_in;

   logic [CNT_W-1:0]  pos_w;
   logic [SLOT_W-1:0] alloc_slot;
   logic [SLOT_W-1:0] idx_w;
   logic [GEN_W-1:0]  gen_eff;
   status_type        rel_st;
   logic              commit;
   logic              freed;
   logic              fp;
   logic [SLOT_W-1:0] fi;
   logic              push_ok;
   logic              load;
   logic [CNT_W-1:0]  cfg_size;
   logic [ENT_W-1:0]  gen_addr;

   assign pos_w      = cnt_ff[pool_ff] - CNT_W'(1);
   assign alloc_slot = below_ff ? synth_ff : stk_q_ff;
   assign idx_w      = SLOT_W'(idx_ff);
   assign gen_eff    = gvq_ff ? gen_q_ff : '0;
   assign freed      = pv_q_ff <= epoch_ff;
   assign fp         = ps_q_ff[ENT_W-1];
   assign fi         = ps_q_ff[SLOT_W-1:0];
   assign push_ok    = cnt_ff[fp] < CNT_W'(SLOTS_PER_POOL);
   assign gen_addr   = cmd.alloc_gen_rd ? {pool_ff, alloc_slot} : {pool_ff, idx_w};

   // clamp to 1 .. SLOTS_PER_POOL
   always_comb begin
      priority if (cfg_data == '0) begin
         cfg_size = CNT_W'(1);
      end else if (32'(cfg_data) > SLOTS_PER_POOL) begin
         cfg_size = CNT_W'(SLOTS_PER_POOL);
      end else begin
         cfg_size = CNT_W'(cfg_data);
      end
   end

   always_comb begin
      priority if (32'(idx_ff) >= 32'(size_ff[pool_ff]) ||
                   32'(idx_ff) >= SLOTS_PER_POOL) begin
         rel_st = ST_RANGE;
      end else if (idx_ff == '0) begin
         rel_st = ST_DEFAULT;
      end else if (hgen_ff != gen_eff) begin
         rel_st = ST_STALE;
      end else if (pcnt_ff >= PCNT_W'(PENDING_DEPTH)) begin
         rel_st = ST_EXHAUSTED;
      end else begin
         rel_st = ST_OK;
      end
   end
   assign commit = cmd.rel_finish && (rel_st == ST_OK);

   // pool counters; low mark is the lowest count since the last rebuild
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         size_in[p] = size_ff[p];
         cnt_in[p]  = cnt_ff[p];
         low_in[p]  = low_ff[p];
      end
      if (cmd.alloc_pop) begin
         cnt_in[pool_ff] = pos_w;
         if (pos_w < low_ff[pool_ff]) low_in[pool_ff] = pos_w;
      end
      if (cmd.col_eval && freed && push_ok) begin
         cnt_in[fp] = cnt_ff[fp] + CNT_W'(1);
      end
      if (cfg_we) begin
         size_in[cfg_sel] = cfg_size;
         cnt_in[cfg_sel]  = cfg_size - CNT_W'(1);
         low_in[cfg_sel]  = cfg_size - CNT_W'(1);
      end
   end

   always_comb begin
      gvld_in = gvld_ff;
      if (commit) gvld_in[{pool_ff, idx_w}] = 1'b1;
      pcnt_in = pcnt_ff;
      if (commit) pcnt_in = pcnt_ff + PCNT_W'(1);
      if (cmd.emit && cmd.kind == EMIT_COL_END) pcnt_in = keep_ff;
      k_in    = k_ff;
      keep_in = keep_ff;
      hold_vld_in = hold_vld_ff;
      if (cmd.col_init) begin
         k_in        = '0;
         keep_in     = '0;
         hold_vld_in = 1'b0;
      end
      if (cmd.col_eval) begin
         k_in = k_ff + PCNT_W'(1);
         if (freed) hold_vld_in = 1'b1;
         else       keep_in = keep_ff + PCNT_W'(1);
      end
   end

   always_comb begin
      load         = cmd.emit | (cmd.col_eval & freed & hold_vld_ff);
      out_st_in    = ST_OK;
      out_pool_in  = 1'b0;
      out_idx_in   = '0;
      out_gen_in   = '0;
      out_freed_in = 1'b0;
      out_last_in  = 1'b1;
      if (cmd.col_eval) begin
         out_pool_in  = hold_pool_ff;
         out_idx_in   = IDX_W'(hold_slot_ff);
         out_freed_in = 1'b1;
         out_last_in  = 1'b0;
      end else begin
         unique case (cmd.kind)
            EMIT_ALLOC_EMPTY: begin
               out_st_in   = ST_EXHAUSTED;
               out_pool_in = pool_ff;
            end
            EMIT_ALLOC: begin
               out_pool_in = pool_ff;
               out_idx_in  = IDX_W'(alloc_slot);
               out_gen_in  = gen_eff;
            end
            EMIT_RELEASE: begin
               out_st_in   = rel_st;
               out_pool_in = pool_ff;
               out_idx_in  = idx_ff;
            end
            EMIT_COL_END: begin
               if (hold_vld_ff) begin
                  out_pool_in  = hold_pool_ff;
                  out_idx_in   = IDX_W'(hold_slot_ff);
                  out_freed_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < 2; p++) begin
            size_ff[p] <= CNT_W'(SLOTS_PER_POOL);
            cnt_ff[p]  <= CNT_W'(SLOTS_PER_POOL - 1);
            low_ff[p]  <= CNT_W'(SLOTS_PER_POOL - 1);
         end
         gvld_ff     <= '0;
         pcnt_ff     <= '0;
         k_ff        <= '0;
         keep_ff     <= '0;
         hold_vld_ff <= 1'b0;
         cur_ret_ff  <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         size_ff     <= size_in;
         cnt_ff      <= cnt_in;
         low_ff      <= low_in;
         gvld_ff     <= gvld_in;
         pcnt_ff     <= pcnt_in;
         k_ff        <= k_in;
         keep_ff     <= keep_in;
         hold_vld_ff <= hold_vld_in;
         if (cmd.set_ret) cur_ret_ff <= epoch_ff;
         if (load)           out_vld_ff <= 1'b1;
         else if (rsp_ready) out_vld_ff <= 1'b0;
      end
   end

   // payload registers and memories
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         pool_ff  <= req_pool;
         idx_ff   <= req_slot_index;
         hgen_ff  <= req_handle_generation;
         epoch_ff <= req_epoch_value;
      end
      if (cmd.alloc_pop) begin
         stk_q_ff <= stk_mem[{pool_ff, pos_w[SLOT_W-1:0]}];
         below_ff <= pos_w < low_ff[pool_ff];
         synth_ff <= SLOT_W'(size_ff[pool_ff] - CNT_W'(1) - pos_w);
      end
      if (cmd.col_eval && freed && push_ok) begin
         stk_mem[{fp, cnt_ff[fp][SLOT_W-1:0]}] <= fi;
      end
      if (cmd.alloc_gen_rd || cmd.rel_gen_rd) begin
         gen_q_ff <= gen_mem[gen_addr];
         gvq_ff   <= gvld_ff[gen_addr];
      end
      if (commit) begin
         gen_mem[{pool_ff, idx_w}] <= gen_eff + GEN_W'(1);
      end
      if (commit) begin
         pv_mem[pcnt_ff[PEND_W-1:0]] <= cur_ret_ff;
         ps_mem[pcnt_ff[PEND_W-1:0]] <= {pool_ff, idx_w};
      end else if (cmd.col_eval && !freed) begin
         pv_mem[keep_ff[PEND_W-1:0]] <= pv_q_ff;
         ps_mem[keep_ff[PEND_W-1:0]] <= ps_q_ff;
      end
      if (cmd.col_rd) begin
         pv_q_ff <= pv_mem[k_ff[PEND_W-1:0]];
         ps_q_ff <= ps_mem[k_ff[PEND_W-1:0]];
      end
      if (cmd.col_eval && freed) begin
         hold_pool_ff <= fp;
         hold_slot_ff <= fi;
      end
      if (load) begin
         out_st_ff    <= out_st_in;
         out_pool_ff  <= out_pool_in;
         out_idx_ff   <= out_idx_in;
         out_gen_ff   <= out_gen_in;
         out_freed_ff <= out_freed_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign stat.alloc_empty = cnt_ff[pool_ff] == '0;
   assign stat.pend_empty  = pcnt_ff == '0;
   assign stat.col_last    = k_ff == (pcnt_ff - PCNT_W'(1));
   assign stat.out_free    = !out_vld_ff || rsp_ready;

   assign size_rd[0] = SIZE_W'(size_ff[0]);
   assign size_rd[1] = SIZE_W'(size_ff[1]);

   assign rsp_valid             = out_vld_ff;
   assign rsp_status            = out_st_ff;
   assign rsp_result_pool       = out_pool_ff;
   assign rsp_result_index      = out_idx_ff;
   assign rsp_result_generation = out_gen_ff;
   assign rsp_freed_valid       = out_freed_ff;
   assign rsp_last              = out_last_ff;

   a_low_le_cnt: assert property (@(posedge clock) disable iff (reset)
      low_ff[0] <= cnt_ff[0] && low_ff[1] <= cnt_ff[1])
      else $error("free stack low mark above count");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff[0]) <= SLOTS_PER_POOL && 32'(cnt_ff[1]) <= SLOTS_PER_POOL)
      else $error("free count overflow");
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pcnt_ff) <= PENDING_DEPTH && keep_ff <= k_ff)
      else $error("pending queue bookkeeping broken");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(commit && cmd.col_eval))
      else $error("two pending queue writers at once");

endmodule
`default_nettype wire

FILE: src/generational_slot_allocator.sv
// generational_slot_allocator: top level, APB CSR decode and unit wiring.
// Depends on gsa_pkg, gsa_ctrl and gsa_dp.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_ready   action, pool, slot_index, generation, epoch
//  rsp      out        rsp_valid / rsp_ready   status, pool, index, generation, freed, last
//  csr      in         psel/penable/pwrite     pool sizes at byte 0 and 4, pready tied high
//
// Steps per transaction, counted from acceptance until ready again:
//   allocate: stack read, generation read, result; only a result when the pool is exhausted,
//   release: generation read, then result; set retirement: result,
//   collect: start, then one registered queue read and one evaluate step per pending
//   entry (through the two queue memories, read at the same index), then an end step.
// Reset is synchronous; it rebuilds both free stacks and clears all
// generations (valid bits) and the pending queue count. No clearing pass.
// A full result register that is not taken stalls the emitting step and every
// collect evaluate step, kept entry or not.
`default_nettype none
module generational_slot_allocator import gsa_pkg::*; #(
   parameter int PENDING_DEPTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic               req_pool,
   input  wire logic [IDX_W-1:0]   req_slot_index,
   input  wire logic [GEN_W-1:0]   req_handle_generation,
   input  wire logic [EPOCH_W-1:0] req_epoch_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [STAT_W-1:0]       rsp_status,
   output logic                    rsp_result_pool,
   output logic [IDX_W-1:0]        rsp_result_index,
   output logic [GEN_W-1:0]        rsp_result_generation,
   output logic                    rsp_freed_valid,
   output logic                    rsp_last,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   cmd_type           cmd;
   stat_type          stat;
   logic              cfg_we;
   logic [SIZE_W-1:0] size_rd [2];

   // pready is tied high, so the access phase always completes a transaction
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_STORAGE_SIZE) ? 32'(size_rd[1])
                                                          : 32'(size_rd[0]);

   gsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gsa_dp #(
      .PENDING_DEPTH  (PENDING_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_pool              (req_pool),
      .req_slot_index        (req_slot_index),
      .req_handle_generation (req_handle_generation),
      .req_epoch_value       (req_epoch_value),
      .cfg_we                (cfg_we),
      .cfg_sel               (csr_paddr[2]),
      .cfg_data              (csr_pwdata[SIZE_W-1:0]),
      .size_rd               (size_rd),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_result_pool       (rsp_result_pool),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .rsp_freed_valid       (rsp_freed_valid),
      .rsp_last              (rsp_last)
   );

endmodule
`default_nettype wire
